[hw/rtl/efb_pkg.sv]
package efb_pkg;

    localparam int MAX_PAYLOAD = 1472;
    localparam int QUEUE_DEPTH = 4;

    localparam int LEN_W      = 11;
    localparam int S_TDATA_W  = 120;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int IDX_W      = 6;

    typedef enum logic [1:0] {
        CMD_SYN  = 2'd0,
        CMD_UDP  = 2'd1,
        CMD_PAY  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SRC_MAC = 2'd0,
        REG_DST_MAC = 2'd1,
        REG_SRC_IP  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        DK_SYN = 2'd0,
        DK_UDP = 2'd1,
        DK_PAY = 2'd2
    } desc_kind_t;

    typedef struct packed {
        desc_kind_t       kind;
        logic [31:0]      dest_ip;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [31:0]      isn;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        logic             last;
    } desc_t;

    typedef struct packed {
        logic             is_syn;
        logic [31:0]      dest_ip;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [31:0]      isn;
        logic [LEN_W-1:0] len;
    } hdr_fields_t;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  TCP_DOFF       = 8'h50;
    localparam logic [7:0]  TCP_FLAGS_SYN  = 8'h02;
    localparam logic [15:0] TCP_WINDOW     = 16'hFFFF;
    localparam logic [15:0] IP_HDR_LEN     = 16'd20;
    localparam logic [15:0] TCP_HDR_LEN    = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;

    localparam logic [IDX_W-1:0] SYN_LAST_IDX = 6'd53;
    localparam logic [IDX_W-1:0] UDP_LAST_IDX = 6'd41;

    // Fixed words of the IPv4 header (ver/ihl/tos, ttl) and of the TCP SYN
    // segment plus pseudo-header (proto, tcp length, offset/flags, window).
    localparam logic [19:0] IP_CSUM_BASE =
        20'({IP_VER_IHL, 8'h00}) + 20'({IP_TTL, 8'h00});
    localparam logic [20:0] TCP_CSUM_BASE =
        21'(PROTO_TCP) + 21'(TCP_HDR_LEN) + 21'({TCP_DOFF, TCP_FLAGS_SYN}) + 21'(TCP_WINDOW);

endpackage

[hw/rtl/efb_front.sv]
module efb_front
    import efb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 q_full,
    output logic                 push,
    output desc_t                push_desc
);

    logic [LEN_W-1:0] remaining_reg, remaining_next;
    logic             accept;
    logic [LEN_W-1:0] plen, plen_sat;
    logic [31:0]      dest_ip;
    logic [15:0]      sport, dport;
    logic [31:0]      isn;
    logic [7:0]       pbyte;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign dest_ip  = s_tdata[31:0];
    assign sport    = s_tdata[47:32];
    assign dport    = s_tdata[63:48];
    assign isn      = s_tdata[95:64];
    assign plen     = s_tdata[106:96];
    assign pbyte    = s_tdata[114:107];

    assign plen_sat = (32'(plen) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : plen;

    always_comb begin
        remaining_next      = remaining_reg;
        push                = 1'b0;
        push_desc.kind      = DK_PAY;
        push_desc.dest_ip   = dest_ip;
        push_desc.sport     = sport;
        push_desc.dport     = dport;
        push_desc.isn       = isn;
        push_desc.len       = plen_sat;
        push_desc.data      = pbyte;
        push_desc.last      = (remaining_reg == LEN_W'(1));
        if (accept) begin
            unique case (s_tuser)
                CMD_SYN: begin
                    push           = 1'b1;
                    push_desc.kind = DK_SYN;
                    remaining_next = '0;
                end
                CMD_UDP: begin
                    push           = 1'b1;
                    push_desc.kind = DK_UDP;
                    remaining_next = plen_sat;
                end
                CMD_PAY: begin
                    // no open frame: byte is dropped
                    if (remaining_reg != '0) begin
                        push           = 1'b1;
                        remaining_next = remaining_reg - LEN_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
        end else begin
            remaining_reg <= remaining_next;
        end
    end

endmodule

[hw/rtl/efb_queue.sv]
module efb_queue
    import efb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output desc_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[hw/rtl/efb_csum.sv]
module efb_csum
    import efb_pkg::*;
(
    input  logic        aclk,
    input  hdr_fields_t cur,
    input  logic [31:0] source_ip,
    output logic [15:0] ip_csum,
    output logic [15:0] tcp_csum
);

    // Free-running three-stage pipeline; the header fields stay put for the
    // whole frame, so the result settles long before byte 24 goes out.
    logic [17:0] addr_sum_reg;
    logic [17:0] tcp_sum_reg;
    logic [15:0] total_reg;
    logic [7:0]  proto_reg;
    logic [19:0] ip_raw_reg;
    logic [20:0] tcp_raw_reg;
    logic [15:0] ip_csum_reg;
    logic [15:0] tcp_csum_reg;
    logic [15:0] total;

    function automatic logic [15:0] fold_inv(input logic [20:0] x);
        logic [16:0] x1;
        logic [15:0] x2;
        x1 = 17'(x[15:0]) + 17'(x[20:16]);
        x2 = x1[15:0] + 16'(x1[16]);
        return ~x2;
    endfunction

    assign total = cur.is_syn ? (IP_HDR_LEN + TCP_HDR_LEN)
                              : (IP_HDR_LEN + UDP_HDR_LEN + 16'(cur.len));

    always_ff @(posedge aclk) begin
        addr_sum_reg <= 18'(source_ip[31:16]) + 18'(source_ip[15:0])
                      + 18'(cur.dest_ip[31:16]) + 18'(cur.dest_ip[15:0]);
        tcp_sum_reg  <= 18'(cur.sport) + 18'(cur.dport)
                      + 18'(cur.isn[31:16]) + 18'(cur.isn[15:0]);
        total_reg    <= total;
        proto_reg    <= cur.is_syn ? PROTO_TCP : PROTO_UDP;

        ip_raw_reg   <= 20'(addr_sum_reg) + 20'(total_reg) + 20'(proto_reg) + IP_CSUM_BASE;
        tcp_raw_reg  <= 21'(addr_sum_reg) + 21'(tcp_sum_reg) + TCP_CSUM_BASE;

        ip_csum_reg  <= fold_inv(21'(ip_raw_reg));
        tcp_csum_reg <= fold_inv(tcp_raw_reg);
    end

    assign ip_csum  = ip_csum_reg;
    assign tcp_csum = tcp_csum_reg;

endmodule

[hw/rtl/efb_back.sv]
module efb_back
    import efb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  desc_t                head,
    output logic                 pop,
    input  logic [47:0]          source_mac,
    input  logic [47:0]          dest_mac,
    input  logic [31:0]          source_ip,
    input  logic [15:0]          ip_csum,
    input  logic [15:0]          tcp_csum,
    output hdr_fields_t          cur,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int HDR_SLOTS = 2 ** IDX_W;

    logic             active_reg, active_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    hdr_fields_t      cur_reg, cur_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic             load_hdr;

    logic [7:0]       hb [HDR_SLOTS];
    logic [IDX_W-1:0] last_idx;
    logic [15:0]      ip_total;
    logic [15:0]      udp_len;
    logic             slot_free;

    assign cur       = cur_reg;
    assign slot_free = !m_valid_reg || m_tready;
    assign last_idx  = cur_reg.is_syn ? SYN_LAST_IDX : UDP_LAST_IDX;
    assign udp_len   = UDP_HDR_LEN + 16'(cur_reg.len);
    assign ip_total  = cur_reg.is_syn ? (IP_HDR_LEN + TCP_HDR_LEN) : (IP_HDR_LEN + udp_len);

    always_comb begin
        for (int i = 0; i < HDR_SLOTS; i++) begin
            hb[i] = 8'h00;
        end
        for (int i = 0; i < 6; i++) begin
            hb[i]     = dest_mac[8*(5-i) +: 8];
            hb[6 + i] = source_mac[8*(5-i) +: 8];
        end
        hb[12] = ETHERTYPE_IPV4[15:8];
        hb[13] = ETHERTYPE_IPV4[7:0];
        hb[14] = IP_VER_IHL;
        hb[16] = ip_total[15:8];
        hb[17] = ip_total[7:0];
        hb[22] = IP_TTL;
        hb[23] = cur_reg.is_syn ? PROTO_TCP : PROTO_UDP;
        hb[24] = ip_csum[15:8];
        hb[25] = ip_csum[7:0];
        for (int i = 0; i < 4; i++) begin
            hb[26 + i] = source_ip[8*(3-i) +: 8];
            hb[30 + i] = cur_reg.dest_ip[8*(3-i) +: 8];
        end
        hb[34] = cur_reg.sport[15:8];
        hb[35] = cur_reg.sport[7:0];
        hb[36] = cur_reg.dport[15:8];
        hb[37] = cur_reg.dport[7:0];
        if (cur_reg.is_syn) begin
            for (int i = 0; i < 4; i++) begin
                hb[38 + i] = cur_reg.isn[8*(3-i) +: 8];
            end
            hb[46] = TCP_DOFF;
            hb[47] = TCP_FLAGS_SYN;
            hb[48] = TCP_WINDOW[15:8];
            hb[49] = TCP_WINDOW[7:0];
            hb[50] = tcp_csum[15:8];
            hb[51] = tcp_csum[7:0];
        end else begin
            hb[38] = udp_len[15:8];
            hb[39] = udp_len[7:0];
        end
    end

    always_comb begin
        active_next  = active_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        pop          = 1'b0;
        load_hdr     = 1'b0;
        cur_next     = cur_reg;
        if (slot_free) begin
            m_valid_next = 1'b0;
            if (active_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = hb[idx_reg];
                m_last_next  = (idx_reg == last_idx) &&
                               (cur_reg.is_syn || (cur_reg.len == '0));
                if (idx_reg == last_idx) begin
                    active_next = 1'b0;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end else if (q_not_empty) begin
                pop = 1'b1;
                if (head.kind == DK_PAY) begin
                    m_valid_next = 1'b1;
                    m_data_next  = head.data;
                    m_last_next  = head.last;
                end else begin
                    // header: latch fields, then serialize the header bytes
                    load_hdr         = 1'b1;
                    active_next      = 1'b1;
                    idx_next         = '0;
                    cur_next.is_syn  = (head.kind == DK_SYN);
                    cur_next.dest_ip = head.dest_ip;
                    cur_next.sport   = head.sport;
                    cur_next.dport   = head.dport;
                    cur_next.isn     = head.isn;
                    cur_next.len     = head.len;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        if (load_hdr) begin
            cur_reg <= cur_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

[hw/rtl/eth_ipv4_syn_udp_frame_builder_core.sv]
// Ethernet/IPv4 frame builder for TCP SYN frames and UDP frames.
//
// Input stream: s_tuser carries the command (SYN frame, UDP header start,
// payload byte); s_tdata carries addresses, ports, sequence number, payload
// length and the payload byte. A SYN command produces a full 54-byte frame;
// a UDP command produces the 42-byte header and opens a frame whose payload
// bytes follow one per payload command. Output stream: one frame byte per
// transfer on m_tdata, m_tlast on the final byte of a frame. MAC addresses
// and the source IP go in through the APB port at byte addresses 0, 8 and 16;
// the user writes them only while the block is idle, which it does not enforce.
//
// A command passes through the descriptor FIFO; a popped header is latched into the byte
// engine and its bytes go out through the output register, while a popped payload byte
// goes straight to the output register when the engine is idle. A SYN frame or UDP header
// holds the byte engine until its last header byte is out; payload bytes stream at one per
// cycle while m_tready stays high. Commands queue in the short FIFO, so input keeps being
// taken while a header is serialized until the FIFO fills. Checksums come from a
// three-stage pipeline fed by the latched header. Reset clears the FIFO, the open-frame
// byte count and the config registers. A stall on m_tready holds the current byte; the
// front side keeps taking commands until the FIFO is full.
module eth_ipv4_syn_udp_frame_builder_core
    import efb_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] dest_ip, [47:32] src_port_num, [63:48] dst_port_num,
    // [95:64] initial_sequence, [106:96] payload_length, [114:107] payload_byte
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [S_TUSER_W-1:0]  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] frame_byte
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [47:0] source_mac_reg;
    logic [47:0] dest_mac_reg;
    logic [31:0] source_ip_reg;
    logic        cfg_wr;
    logic [1:0]  reg_sel;

    logic        q_full;
    logic        q_not_empty;
    logic        push;
    logic        pop;
    desc_t       push_desc;
    desc_t       head;
    hdr_fields_t cur;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_mac_reg <= '0;
            dest_mac_reg   <= '0;
            source_ip_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_SRC_MAC: source_mac_reg <= pwdata[47:0];
                REG_DST_MAC: dest_mac_reg   <= pwdata[47:0];
                REG_SRC_IP:  source_ip_reg  <= pwdata[31:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SRC_MAC: prdata = {16'h0000, source_mac_reg};
            REG_DST_MAC: prdata = {16'h0000, dest_mac_reg};
            REG_SRC_IP:  prdata = {32'h0000_0000, source_ip_reg};
            default:     prdata = '0;
        endcase
    end

    efb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    efb_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    efb_csum u_csum (
        .aclk      (aclk),
        .cur       (cur),
        .source_ip (source_ip_reg),
        .ip_csum   (ip_csum),
        .tcp_csum  (tcp_csum)
    );

    efb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .source_mac  (source_mac_reg),
        .dest_mac    (dest_mac_reg),
        .source_ip   (source_ip_reg),
        .ip_csum     (ip_csum),
        .tcp_csum    (tcp_csum),
        .cur         (cur),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

[test/frame_stream_checker.sv]
`timescale 1ns / 1ps

module frame_stream_checker
    import efb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,

    output int                    pending,
    output int                    errors
);

    localparam logic [15:0] ETHTYPE_IP4     = 16'h0800;
    localparam logic [7:0]  HDR_VER_IHL     = 8'h45;
    localparam logic [7:0]  HDR_TTL         = 8'd64;
    localparam logic [7:0]  IPPROTO_TCP     = 8'd6;
    localparam logic [7:0]  IPPROTO_UDP     = 8'd17;
    localparam logic [7:0]  TCP_OFFSET_BYTE = 8'h50;
    localparam logic [7:0]  TCP_SYN_FLAG    = 8'h02;
    localparam logic [15:0] TCP_WIN         = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    frame_beat_t      expected_bytes[$];
    logic [47:0]      src_mac;
    logic [47:0]      dst_mac;
    logic [31:0]      src_ip;
    logic [LEN_W-1:0] open_left;
    int               mism;
    int               out_count;

    function automatic logic [15:0] ones_fold(input logic [31:0] sum_in);
        logic [31:0] s;
        s = sum_in;
        while (s[31:16] != 16'd0)
            s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        return ~s[15:0];
    endfunction

    task automatic push_header(input logic is_syn, input logic [31:0] dip,
                               input logic [15:0] sp, input logic [15:0] dp,
                               input logic [31:0] isn, input logic [LEN_W-1:0] plen);
        logic [7:0]  hb [54];
        logic [31:0] sum;
        int          n;
        frame_beat_t beat;
        foreach (hb[i]) hb[i] = 8'h00;
        for (int i = 0; i < 6; i++) begin
            hb[i]     = dst_mac[8*(5-i) +: 8];
            hb[6 + i] = src_mac[8*(5-i) +: 8];
        end
        {hb[12], hb[13]} = ETHTYPE_IP4;
        hb[14] = HDR_VER_IHL;
        {hb[16], hb[17]} = is_syn ? 16'd40 : 16'd28 + 16'(plen);
        hb[22] = HDR_TTL;
        hb[23] = is_syn ? IPPROTO_TCP : IPPROTO_UDP;
        {hb[26], hb[27], hb[28], hb[29]} = src_ip;
        {hb[30], hb[31], hb[32], hb[33]} = dip;
        sum = 32'd0;
        for (int i = 14; i < 34; i += 2)
            sum += {16'd0, hb[i], hb[i+1]};
        {hb[24], hb[25]} = ones_fold(sum);

        {hb[34], hb[35]} = sp;
        {hb[36], hb[37]} = dp;
        if (is_syn) begin
            {hb[38], hb[39], hb[40], hb[41]} = isn;
            hb[46] = TCP_OFFSET_BYTE;
            hb[47] = TCP_SYN_FLAG;
            {hb[48], hb[49]} = TCP_WIN;
            // pseudo-header: addresses, protocol, segment length
            sum = {16'd0, src_ip[31:16]} + {16'd0, src_ip[15:0]}
                + {16'd0, dip[31:16]} + {16'd0, dip[15:0]} + 32'd6 + 32'd20;
            for (int i = 34; i < 54; i += 2)
                sum += {16'd0, hb[i], hb[i+1]};
            {hb[50], hb[51]} = ones_fold(sum);
            n = 54;
        end else begin
            {hb[38], hb[39]} = 16'd8 + 16'(plen);
            n = 42;
        end

        for (int i = 0; i < n; i++) begin
            beat.data = hb[i];
            beat.last = (i == n - 1) && (is_syn || plen == '0);
            expected_bytes.push_back(beat);
        end
    endtask

    task automatic take_command(input cmd_t cmd, input logic [S_TDATA_W-1:0] d);
        logic [LEN_W-1:0] plen;
        frame_beat_t      beat;
        case (cmd)
            CMD_SYN: begin
                open_left = '0;
                push_header(1'b1, d[31:0], d[47:32], d[63:48], d[95:64], '0);
            end
            CMD_UDP: begin
                plen = d[106:96];
                if (32'(plen) > MAX_PAYLOAD)
                    plen = LEN_W'(MAX_PAYLOAD);
                push_header(1'b0, d[31:0], d[47:32], d[63:48], d[95:64], plen);
                open_left = plen;
            end
            CMD_PAY: begin
                // dropped when no frame is open
                if (open_left != '0) begin
                    open_left = open_left - LEN_W'(1);
                    beat.data = d[114:107];
                    beat.last = (open_left == '0);
                    expected_bytes.push_back(beat);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        frame_beat_t want;
        if (!aresetn) begin
            expected_bytes.delete();
            src_mac   = '0;
            dst_mac   = '0;
            src_ip    = '0;
            open_left = '0;
            out_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[CFG_ADDR_W-1:3]))
                    REG_SRC_MAC: src_mac = pwdata[47:0];
                    REG_DST_MAC: dst_mac = pwdata[47:0];
                    REG_SRC_IP:  src_ip  = pwdata[31:0];
                    default: ;
                endcase
            end
            // outputs are checked before this edge's input is predicted
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    mism++;
                    if (mism <= 10)
                        $display("byte %0d: unexpected %02h last %0b",
                                 out_count, m_tdata, m_tlast);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.data !== m_tdata || want.last !== m_tlast) begin
                        mism++;
                        if (mism <= 10)
                            $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                                     out_count, want.data, want.last, m_tdata, m_tlast);
                    end
                end
                out_count++;
            end
            if (s_tvalid && s_tready)
                take_command(cmd_t'(s_tuser[1:0]), s_tdata);
        end
        pending <= expected_bytes.size();
        errors  <= mism;
    end

endmodule

[test/tb_eth_ipv4_syn_udp_frame_builder_core.sv]
`timescale 1ns / 1ps

module tb_eth_ipv4_syn_udp_frame_builder_core;
    import efb_pkg::*;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [31:0] dest_ip, [47:32] src_port_num, [63:48] dst_port_num,
    // [95:64] initial_sequence, [106:96] payload_length, [114:107] payload_byte
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // [1:0] command
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [7:0] frame_byte
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int errors;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit rx_hold  = 1'b0;

    eth_ipv4_syn_udp_frame_builder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    frame_stream_checker u_chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pending  (pending),
        .errors   (errors)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end
            stall = rx_quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic cfg_write(input reg_idx_t idx, input logic [47:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(input cmd_t cmd, input logic [31:0] dip, input logic [15:0] sp,
                             input logic [15:0] dp, input logic [31:0] isn,
                             input logic [10:0] len, input logic [7:0] pb);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, pb, len, isn, dp, sp, dip};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_rand(input cmd_t cmd, input logic [10:0] len);
        send_item(cmd, $urandom(), 16'($urandom()), 16'($urandom()), $urandom(), len,
                  8'($urandom()));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // well-formed frames with random content, plus stray and broken ones
    task automatic run_traffic(input int target);
        int         counted;
        int         r;
        int         nb;
        bit         cut;
        logic [10:0] len;
        counted = 0;
        while (counted < target) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_rand(CMD_SYN, 11'($urandom()));
                counted++;
            end else if (r < 80) begin
                cut = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 15) == 0) begin
                    len = 11'($urandom_range(1473, 2047));
                    cut = 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    len = 11'($urandom_range(0, 60));
                end else begin
                    len = 11'($urandom_range(0, 6));
                end
                nb = cut ? $urandom_range(0, 5) : int'(len);
                send_rand(CMD_UDP, len);
                counted++;
                for (int i = 0; i < nb; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_rand(CMD_NONE, 11'($urandom()));
                    send_rand(CMD_PAY, 11'($urandom()));
                    counted++;
                end
            end else if (r < 90) begin
                send_rand(CMD_PAY, 11'($urandom()));
            end else begin
                send_rand(CMD_NONE, 11'($urandom()));
            end
        end
    endtask

    initial begin
        logic [47:0] mac_a;
        logic [47:0] mac_b;
        logic [31:0] ip_c;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cfg_write(REG_SRC_MAC, 48'hFFFF_FFFF_FFFF);
        cfg_write(REG_DST_MAC, 48'hFFFF_FFFF_FFFF);
        cfg_write(REG_SRC_IP, 48'h0000_FFFF_FFFF);

        // stray byte and unused command with no frame open
        send_item(CMD_PAY, '0, '0, '0, '0, '0, 8'hAA);
        send_rand(CMD_NONE, '0);
        send_item(CMD_SYN, '0, '0, '0, '0, '0, '0);
        send_item(CMD_SYN, '1, '1, '1, '1, '1, '1);
        send_item(CMD_UDP, '1, '1, '1, '1, 11'd0, '1);
        send_rand(CMD_UDP, 11'd1);
        send_item(CMD_PAY, '0, '0, '0, '0, '0, 8'h00);
        send_item(CMD_PAY, '1, '1, '1, '1, '1, 8'hFF);
        send_item(CMD_UDP, '0, '0, '0, '0, 11'd2, '0);
        send_item(CMD_PAY, '0, '0, '0, '0, '0, 8'hFF);
        send_rand(CMD_NONE, '1);
        send_item(CMD_PAY, '0, '0, '0, '0, '0, 8'h00);
        // oversized lengths saturate; a new header abandons the open frame
        send_rand(CMD_UDP, 11'd2047);
        send_rand(CMD_PAY, '0);
        send_rand(CMD_PAY, '0);
        send_rand(CMD_UDP, 11'd1473);
        send_rand(CMD_PAY, '0);
        send_rand(CMD_SYN, '0);
        send_rand(CMD_PAY, '0);
        send_rand(CMD_UDP, 11'd1472);
        send_rand(CMD_PAY, '0);
        send_rand(CMD_UDP, 11'd3);
        repeat (3) send_rand(CMD_PAY, '0);

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            // idle gap before the config registers are rewritten
            repeat (20) @(posedge aclk);
            case (ph)
                0: begin
                    mac_a = '0;
                    mac_b = '0;
                    ip_c  = '0;
                end
                3: begin
                    mac_a = '0;
                    mac_b = '1;
                    ip_c  = $urandom();
                end
                default: begin
                    mac_a = {16'($urandom()), 32'($urandom())};
                    mac_b = {16'($urandom()), 32'($urandom())};
                    ip_c  = $urandom();
                end
            endcase
            cfg_write(REG_SRC_MAC, mac_a);
            cfg_write(REG_DST_MAC, mac_b);
            cfg_write(REG_SRC_IP, {16'd0, ip_c});
            tx_quiet = (ph == 2);
            rx_quiet = (ph == 2);
            if (ph == 1) begin
                // sink holds off while SYN frames pile up in the FIFO
                rx_hold  = 1'b1;
                tx_quiet = 1'b1;
                repeat (12) send_rand(CMD_SYN, '0);
                tx_quiet = 1'b0;
            end
            run_traffic(55);
        end

        // one UDP frame at line rate
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_rand(CMD_UDP, 11'd24);
        repeat (24) send_rand(CMD_PAY, '0);
        send_rand(CMD_SYN, '0);

        wait_drained();
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
hw/rtl/efb_pkg.sv
hw/rtl/efb_front.sv
hw/rtl/efb_queue.sv
hw/rtl/efb_csum.sv
hw/rtl/efb_back.sv
hw/rtl/eth_ipv4_syn_udp_frame_builder_core.sv
test/frame_stream_checker.sv
test/tb_eth_ipv4_syn_udp_frame_builder_core.sv
